// ===== hw/rtl/temp_scratchpad_crc_display_assert.svh =====
// Assertion macros used by the temperature readout top level.
`ifndef TEMP_SCRATCHPAD_CRC_DISPLAY_ASSERT_SVH
`define TEMP_SCRATCHPAD_CRC_DISPLAY_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define TSCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define TSCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define TSCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/tscd_pkg.sv =====
`default_nettype none
package tscd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] DP_BIT   = 8'h80;
    localparam int unsigned FRAME_LAST = 8;

    localparam logic [7:0] SEG_CODE [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct packed {
        logic        last;
        logic        crc_error;
        logic [11:0] temp_word;
    } t_frame_status;

    typedef struct packed {
        logic       crc_error;
        logic [7:0] crc_segments;
        logic [7:0] tens_segments;
        logic [7:0] ones_segments;
        logic [7:0] tenths_segments;
        logic [7:0] hundredths_segments;
    } t_result;

    // Reflected CRC-8, one bit per step.
    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Quotient by ten via reciprocal 205/2048, exact for values below 1029.
    function automatic logic [6:0] div10(input logic [9:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return p[17:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [9:0] v);
        logic [9:0] r;
        r = v - 10'(div10(v)) * 10'd10;
        return r[3:0];
    endfunction

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] code;
        code = '0;
        if (digit <= 4'd9) begin
            code = SEG_CODE[digit];
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tscd_byte_if.sv =====
`default_nettype none
interface tscd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scratch_byte;

    modport source (output valid, output scratch_byte, input ready);
    modport sink   (input valid, input scratch_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tscd_result_if.sv =====
`default_nettype none
interface tscd_result_if;
    logic       valid;
    logic       ready;
    logic       crc_error;
    logic [7:0] crc_segments;
    logic [7:0] tens_segments;
    logic [7:0] ones_segments;
    logic [7:0] tenths_segments;
    logic [7:0] hundredths_segments;

    modport source (
        output valid, output crc_error, output crc_segments, output tens_segments,
        output ones_segments, output tenths_segments, output hundredths_segments,
        input ready
    );
    modport sink (
        input valid, input crc_error, input crc_segments, input tens_segments,
        input ones_segments, input tenths_segments, input hundredths_segments,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/tscd_frame.sv =====
`default_nettype none
// Frame tracker: byte position, running CRC and raw reading.
module tscd_frame (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_consume,
    input  wire logic [7:0]              i_byte,
    output tscd_pkg::t_frame_status      o_status
);

    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [11:0] r_temp, n_temp;
    logic        last;

    assign last = (r_pos >= 4'(tscd_pkg::FRAME_LAST));

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_temp = r_temp;
        if (i_consume) begin
            if (last) begin
                n_pos = '0;
                n_crc = '0;
            end else begin
                n_pos = r_pos + 4'd1;
                n_crc = tscd_pkg::crc8_update(r_crc, i_byte);
                if (r_pos == 4'd0) begin
                    n_temp = {r_temp[11:8], i_byte};
                end else if (r_pos == 4'd1) begin
                    n_temp = {i_byte[3:0], r_temp[7:0]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= '0;
            r_temp <= '0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_temp <= n_temp;
        end
    end

    assign o_status.last      = last;
    assign o_status.crc_error = (r_crc != i_byte);
    assign o_status.temp_word = r_temp;

endmodule
`default_nettype wire

// ===== hw/rtl/tscd_encode.sv =====
`default_nettype none
// Digit split and seven-segment encoding of one reading.
module tscd_encode (
    input  wire logic [1:0]              i_res_mode,
    input  wire tscd_pkg::t_frame_status i_status,
    output tscd_pkg::t_result            o_result
);

    logic [7:0]  int_part;
    logic [6:0]  int_tens_q;
    logic [3:0]  tens_digit;
    logic [3:0]  ones_digit;
    logic [6:0]  sixteenths;
    logic [10:0] scaled10;
    logic [13:0] scaled100;
    logic [3:0]  tenths_digit;
    logic [3:0]  hundredths_digit;

    assign int_part   = i_status.temp_word[11:4];
    assign int_tens_q = tscd_pkg::div10(10'(int_part));
    assign tens_digit = tscd_pkg::mod10(10'(int_tens_q));
    assign ones_digit = tscd_pkg::mod10(10'(int_part));

    // Fraction held exactly in sixteenths of a degree.
    assign sixteenths = 7'(i_status.temp_word[3:0]) << (2'd3 - i_res_mode);
    assign scaled10   = 11'(sixteenths) * 11'd10;
    assign scaled100  = 14'(sixteenths) * 14'd100;

    assign tenths_digit     = tscd_pkg::mod10(10'(scaled10[10:4]));
    assign hundredths_digit = tscd_pkg::mod10(scaled100[13:4]);

    assign o_result.crc_error           = i_status.crc_error;
    assign o_result.crc_segments        = tscd_pkg::seg_of({3'b000, i_status.crc_error});
    assign o_result.tens_segments       = tscd_pkg::seg_of(tens_digit);
    assign o_result.ones_segments       = tscd_pkg::seg_of(ones_digit) | tscd_pkg::DP_BIT;
    assign o_result.tenths_segments     = tscd_pkg::seg_of(tenths_digit);
    assign o_result.hundredths_segments = tscd_pkg::seg_of(hundredths_digit);

endmodule
`default_nettype wire

// ===== hw/rtl/temp_scratchpad_crc_display.sv =====
// Path: the ninth byte of a frame passes the input register, then the result
//   register, from which its result is shown. Throughput: one byte per cycle
//   unless a result stalls; one result per nine bytes. A stalled result holds
//   the input register, so a byte waits there until the result is taken.
// Reset (i_rst_n low, synchronous): frame restarts at byte 0, CRC and reading
//   clear, res_mode returns to 3, no result is pending.
`default_nettype none
`include "temp_scratchpad_crc_display_assert.svh"
module temp_scratchpad_crc_display (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    tscd_byte_if.sink       i_byte,
    tscd_result_if.source   o_result
);

    // Configuration: resolution mode; the user must write it only while idle, the block does not enforce this.
    logic [1:0] r_res_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_mode <= 2'd3;
        end else if (i_cfg_we) begin
            r_res_mode <= i_cfg_data;
        end
    end

    // Pipeline control. The result register drains when the sink takes it;
    // the input register advances whenever the result register can accept.
    logic r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic r_out_valid, n_out_valid;
    tscd_pkg::t_result r_res;
    logic advance;
    logic consume;
    logic in_ready;

    tscd_pkg::t_frame_status frame_status;
    tscd_pkg::t_result       enc_result;

    assign advance  = !r_out_valid || o_result.ready;
    assign in_ready = !r_in_valid || advance;
    assign consume  = r_in_valid && advance;

    assign i_byte.ready = in_ready;

    // Input register: load on every transfer, drop once consumed.
    always_comb begin
        n_in_valid = r_in_valid;
        if (in_ready) begin
            n_in_valid = i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_in_byte <= i_byte.scratch_byte;
        end
    end

    // Frame tracking: CRC, position and raw reading advance per consumed byte.
    tscd_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_byte    (r_in_byte),
        .o_status  (frame_status)
    );

    // Segment encoding of the stored reading, used on the closing byte.
    tscd_encode u_encode (
        .i_res_mode (r_res_mode),
        .i_status   (frame_status),
        .o_result   (enc_result)
    );

    // Result register: only the closing byte of a frame produces a result.
    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = consume && frame_status.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && frame_status.last) begin
            r_res <= enc_result;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.crc_error           = r_res.crc_error;
    assign o_result.crc_segments        = r_res.crc_segments;
    assign o_result.tens_segments       = r_res.tens_segments;
    assign o_result.ones_segments       = r_res.ones_segments;
    assign o_result.tenths_segments     = r_res.tenths_segments;
    assign o_result.hundredths_segments = r_res.hundredths_segments;

    logic mid_byte;
    logic close_byte;
    logic err_digit_ok;

    assign mid_byte     = consume && !frame_status.last;
    assign close_byte   = consume && frame_status.last;
    assign err_digit_ok = (r_res.crc_segments == tscd_pkg::seg_of({3'b000, r_res.crc_error}));

    // A data byte never leaves a result behind.
    `TSCD_ASSERT_NXT(a_no_result_mid_frame, i_clk, i_rst_n, mid_byte, !r_out_valid)
    // The closing byte always leaves a result behind.
    `TSCD_ASSERT_NXT(a_result_on_last, i_clk, i_rst_n, close_byte, r_out_valid)
    // Error digit agrees with the error flag.
    `TSCD_ASSERT_IMP(a_err_digit, i_clk, i_rst_n, r_out_valid, err_digit_ok)
    // Decimal point sits on the ones digit.
    `TSCD_ASSERT_IMP(a_dp_set, i_clk, i_rst_n, r_out_valid, r_res.ones_segments[7])

endmodule
`default_nettype wire

// ===== verif/tscd_scoreboard_pkg.sv =====
package tscd_scoreboard_pkg;

    // Track the scratchpad frame and queue the readout that each ninth byte should produce.
    class t_readout_scoreboard;
        logic [1:0]        res_mode;
        logic [7:0]        crc_run;
        int unsigned       byte_idx;
        logic [11:0]       raw_reading;
        tscd_pkg::t_result readout_q[$];
        int unsigned       failures;
        int unsigned       readouts;
        int unsigned       crc_errors;

        function new();
            res_mode    = 2'd3;
            crc_run     = 8'h00;
            byte_idx    = 0;
            raw_reading = 12'h000;
            failures    = 0;
            readouts    = 0;
            crc_errors  = 0;
        endfunction

        // Reflected CRC-8, shift right, one bit per step.
        static function logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] data_byte);
            logic [7:0] c;
            c = acc ^ data_byte;
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ tscd_pkg::CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void set_mode(input logic [1:0] mode);
            res_mode = mode;
        endfunction

        function int pending();
            return readout_q.size();
        endfunction

        function void note_byte(input logic [7:0] data_byte);
            tscd_pkg::t_result want;
            logic [7:0]        whole;
            logic [7:0]        sixteenths;
            int unsigned       tenths;
            int unsigned       hundredths;
            if (byte_idx < tscd_pkg::FRAME_LAST) begin
                crc_run = crc_step(crc_run, data_byte);
                if (byte_idx == 0) begin
                    raw_reading[7:0] = data_byte;
                end else if (byte_idx == 1) begin
                    raw_reading[11:8] = data_byte[3:0];
                end
                byte_idx++;
                return;
            end
            whole      = raw_reading[11:4];
            // Fraction held exactly in sixteenths, no rounding.
            sixteenths = 8'(raw_reading[3:0]) << (2'd3 - res_mode);
            tenths     = ((int'(sixteenths) * 10) / 16) % 10;
            hundredths = ((int'(sixteenths) * 100) / 16) % 10;
            want.crc_error           = (crc_run != data_byte);
            want.crc_segments        = tscd_pkg::SEG_CODE[want.crc_error];
            want.tens_segments       = tscd_pkg::SEG_CODE[(whole / 10) % 10];
            want.ones_segments       = tscd_pkg::SEG_CODE[whole % 10] | tscd_pkg::DP_BIT;
            want.tenths_segments     = tscd_pkg::SEG_CODE[tenths];
            want.hundredths_segments = tscd_pkg::SEG_CODE[hundredths];
            if (want.crc_error) begin
                crc_errors++;
            end
            readout_q.push_back(want);
            crc_run  = 8'h00;
            byte_idx = 0;
        endfunction

        function void flag(input string what);
            failures++;
            if (failures <= 10) begin
                $display("%0t: readout %0d: %s", $realtime, readouts, what);
            end
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                flag($sformatf("%s expected 0x%02h got 0x%02h", name, want, got));
            end
        endfunction

        function void check_readout(input tscd_pkg::t_result got);
            tscd_pkg::t_result want;
            if (readout_q.size() == 0) begin
                flag("readout with none outstanding");
                return;
            end
            want = readout_q.pop_front();
            compare_field("crc_error", 8'(want.crc_error), 8'(got.crc_error));
            compare_field("crc_segments", want.crc_segments, got.crc_segments);
            compare_field("tens_segments", want.tens_segments, got.tens_segments);
            compare_field("ones_segments", want.ones_segments, got.ones_segments);
            compare_field("tenths_segments", want.tenths_segments, got.tenths_segments);
            compare_field("hundredths_segments", want.hundredths_segments,
                          got.hundredths_segments);
            readouts++;
        endfunction
    endclass

endpackage

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // How the check byte of a frame relates to the CRC of bytes 0 to 7.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_NOISE
    } t_frame_kind;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;  // long receiver hold-off
    localparam int unsigned PHASE_FRAMES  = 16;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic       cfg_we;
    logic [1:0] cfg_data;

    tscd_byte_if   byte_bus ();
    tscd_result_if result_bus ();

    temp_scratchpad_crc_display i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_byte     (byte_bus),
        .o_result   (result_bus)
    );

    tscd_scoreboard_pkg::t_readout_scoreboard sb;

    int unsigned send_idle_pct = 0;  // chance per cycle that the sender idles
    int unsigned stall_pct     = 0;  // chance per cycle that the receiver stalls
    int unsigned hold_requests = 0;  // bumped by the stimulus to ask for a hold-off
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned bytes_sent    = 0;
    int unsigned modes_written = 0;

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: drive ready at the falling edge. A requested hold-off keeps
    // ready low while hold_left counts down, so the block backs up while
    // the sender keeps offering bytes.
    initial result_bus.ready = 1'b0;
    always @(negedge clk) begin
        if (hold_left != 0) begin
            result_bus.ready = 1'b0;
            hold_left--;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            result_bus.ready = 1'b0;
        end else begin
            result_bus.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: sample both channels at the rising edge. Check the result
    // first so a readout never matches an expectation queued at the same edge.
    always @(posedge clk) begin : monitor
        tscd_pkg::t_result got;
        if (rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                got.crc_error           = result_bus.crc_error;
                got.crc_segments        = result_bus.crc_segments;
                got.tens_segments       = result_bus.tens_segments;
                got.ones_segments       = result_bus.ones_segments;
                got.tenths_segments     = result_bus.tenths_segments;
                got.hundredths_segments = result_bus.hundredths_segments;
                sb.check_readout(got);
            end
            if (byte_bus.valid && byte_bus.ready) begin
                sb.note_byte(byte_bus.scratch_byte);
            end
        end
    end

    // Offer one byte: idle at random first, then hold valid until the
    // transfer. Returns just after the accepting rising edge.
    task automatic send_byte(input logic [7:0] data_byte);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            byte_bus.valid = 1'b0;
            byte_bus.scratch_byte = 8'($urandom);
        end
        @(negedge clk);
        byte_bus.valid = 1'b1;
        byte_bus.scratch_byte = data_byte;
        do begin
            @(posedge clk);
        end while (!byte_bus.ready);
        bytes_sent++;
    endtask

    // Send a nine-byte scratchpad frame. Bytes 2 to 7 repeat byte 1 unless
    // the body is random; the check byte depends on the frame kind.
    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input bit random_body, input t_frame_kind kind);
        logic [7:0] crc;
        logic [7:0] data_byte;
        crc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            data_byte = (i == 0) ? b0 : (i == 1 || !random_body) ? b1 : 8'($urandom);
            crc = tscd_scoreboard_pkg::t_readout_scoreboard::crc_step(crc, data_byte);
            send_byte(data_byte);
        end
        case (kind)
            FRAME_GOOD:    send_byte(crc);
            FRAME_BAD_CRC: send_byte(crc ^ 8'($urandom_range(255, 1)));
            default:       send_byte(8'($urandom));
        endcase
    endtask

    // Drop valid and wait until every readout has come out, then let the
    // pipeline settle.
    task automatic drain_readouts();
        @(negedge clk);
        byte_bus.valid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write res_mode; only called with the block idle at a frame boundary.
    task automatic write_mode(input logic [1:0] mode);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = mode;
        sb.set_mode(mode);
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_data = 2'($urandom);
        modes_written++;
    endtask

    initial begin
        // Resolution settings, extremes first; idle profile advances every two.
        logic [1:0]  mode_seq [8] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd0, 2'd3, 2'd1};
        int unsigned idle_seq [4] = '{0, 68, 0, 20};
        int unsigned stall_seq[4] = '{0, 0, 68, 20};
        int unsigned pick;
        t_frame_kind kind;

        sb = new();
        cfg_we                = 1'b0;
        cfg_data              = 2'd0;
        byte_bus.valid        = 1'b0;
        byte_bus.scratch_byte = 8'h00;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed frames at the reset resolution: all-zero reading with a
        // matching check byte, then all-ones reading (sign bits set) with a
        // corrupted check byte.
        send_frame(8'h00, 8'h00, 1'b0, FRAME_GOOD);
        send_frame(8'hFF, 8'hFF, 1'b0, FRAME_BAD_CRC);
        drain_readouts();

        for (int ph = 0; ph < 8; ph++) begin
            write_mode(mode_seq[ph]);
            send_idle_pct = idle_seq[ph / 2];
            stall_pct     = stall_seq[ph / 2];
            // Back up the block: long receiver hold-off, sender keeps going.
            if (ph == 0) begin
                hold_requests++;
            end
            for (int f = 0; f < PHASE_FRAMES; f++) begin
                // Pause the sender mid-phase until every readout is out.
                if (ph == 5 && f == PHASE_FRAMES / 2) begin
                    drain_readouts();
                end
                pick = $urandom_range(99);
                kind = (pick < 75) ? FRAME_GOOD : (pick < 90) ? FRAME_BAD_CRC : FRAME_NOISE;
                send_frame(8'($urandom), 8'($urandom), 1'b1, kind);
            end
            drain_readouts();
        end

        $display("Sent %0d scratchpad bytes; checked %0d readouts, %0d with a CRC error.",
                 bytes_sent, sb.readouts, sb.crc_errors);
        $display("Covered %0d resolution writes across four idle/stall profiles.",
                 modes_written);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("temp_scratchpad_crc_display verification clean");
        end else begin
            $display("temp_scratchpad_crc_display verification failed");
        end
        $finish;
    end

    // Timeout far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("temp_scratchpad_crc_display verification failed");
        $finish;
    end

endmodule

// ===== temp_scratchpad_crc_display.f =====
+incdir+hw/rtl
hw/rtl/tscd_pkg.sv
hw/rtl/tscd_byte_if.sv
hw/rtl/tscd_result_if.sv
hw/rtl/tscd_frame.sv
hw/rtl/tscd_encode.sv
hw/rtl/temp_scratchpad_crc_display.sv
verif/tscd_scoreboard_pkg.sv
verif/testbench.sv
